### sv/itp_pkg.sv
// Shared types, operator codes and character mapping for the infix-to-postfix converter.
// No dependencies; imported by itp_cell and infix_to_postfix_converter.
`default_nettype none

package itp_pkg;

	// Two-bit operator codes; bit 1 is the precedence (1 for * and /).
	typedef logic [1:0] op_code_t;

	localparam op_code_t OP_ADD = 2'd0;
	localparam op_code_t OP_SUB = 2'd1;
	localparam op_code_t OP_MUL = 2'd2;
	localparam op_code_t OP_DIV = 2'd3;

	localparam logic [7:0] CHAR_ADD = 8'h2B;
	localparam logic [7:0] CHAR_SUB = 8'h2D;
	localparam logic [7:0] CHAR_MUL = 8'h2A;
	localparam logic [7:0] CHAR_DIV = 8'h2F;

	// Shift command applied to every cell of the stack chain in the same cycle.
	typedef enum logic [1:0] {
		STK_HOLD,
		STK_PUSH,
		STK_POP
	} stk_cmd_t;

	typedef struct packed {
		logic     is_op;
		op_code_t code;
	} tok_class_t;

	function automatic tok_class_t classify(input logic [7:0] ch);
		tok_class_t t;
		t.is_op = 1'b1;
		t.code  = OP_ADD;
		unique case (ch)
			CHAR_ADD: t.code = OP_ADD;
			CHAR_SUB: t.code = OP_SUB;
			CHAR_MUL: t.code = OP_MUL;
			CHAR_DIV: t.code = OP_DIV;
			default:  t.is_op = 1'b0;
		endcase
		return t;
	endfunction

	function automatic logic [7:0] op_char(input op_code_t code);
		logic [7:0] c;
		unique case (code)
			OP_ADD:  c = CHAR_ADD;
			OP_SUB:  c = CHAR_SUB;
			OP_MUL:  c = CHAR_MUL;
			default: c = CHAR_DIV;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

### sv/itp_cell.sv
// One entry of the operator stack chain: holds a code and shifts with its neighbors.
// Depends on itp_pkg for the operator code and shift command types.
`default_nettype none

module itp_cell
	import itp_pkg::*;
(
	input  wire logic     clk,
	input  wire stk_cmd_t cmd,
	input  wire op_code_t upper_op,  // from the cell nearer the top, or the pushed code
	input  wire op_code_t lower_op,  // from the cell farther from the top
	output op_code_t      op_q
);

	// Payload only; occupancy is tracked by the count in the controller.
	always_ff @(posedge clk) begin
		unique case (cmd)
			STK_PUSH: op_q <= upper_op;
			STK_POP:  op_q <= lower_op;
			default:  op_q <= op_q;
		endcase
	end

endmodule

`default_nettype wire

### sv/infix_to_postfix_converter.sv
// Top level of the infix-to-postfix converter: stream ports, control sequencer and a
// chain of itp_cell stack entries. Depends on itp_pkg and itp_cell.
//
//   Channel   Dir  Handshake               Payload
//   s_axis    in   s_axis_tvalid/tready    tdata[7:0] token_char, tlast end_of_expression
//   m_axis    out  m_axis_tvalid/tready    tdata[7:0] out_char, tlast last_of_run,
//                                          tuser[0] expression_done, tuser[1] overflow_seen
//
// An item is accepted only while the sequencer is idle and is then handled in ST_WORK; no
// new item is taken until it returns to idle. Each popped or flushed operator needs its own
// step, since the stack chain moves one entry per cycle and one result leaves per cycle.
// The output register lets the last result of an item wait while the next item is taken.
// Stalls on m_axis hold the sequencer only in cycles where it has a result to hand over.
// Reset (arst_n low) clears the sequencer, the stack count, the overflow flag and the
// output valid; the stack entries themselves are not reset.
`default_nettype none

module infix_to_postfix_converter
	import itp_pkg::*;
#(
	parameter int STACK_DEPTH = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,   // [7:0] token_char
	input  wire logic       s_axis_tlast,   // end_of_expression
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata,   // [7:0] out_char
	output logic            m_axis_tlast,   // last_of_run
	output logic [1:0]      m_axis_tuser    // [0] expression_done, [1] overflow_seen
);

	localparam int CntW = $clog2(STACK_DEPTH + 1);
	localparam logic [CntW-1:0] CntFull = CntW'(STACK_DEPTH);
	localparam logic [CntW-1:0] CntOne  = CntW'(1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WORK,
		ST_FLUSH
	} state_t;

	state_t          state_q, state_d;
	logic [CntW-1:0] count_q, count_d;
	logic            flag_q, flag_d;

	// Item held while it is worked on.
	logic [7:0] ch_q;
	logic       eoe_q;
	tok_class_t tok_q;

	// Output register.
	logic       out_valid_q;
	logic [7:0] out_char_q;
	logic       out_last_q;
	logic       out_done_q;
	logic       out_ovf_q;

	// Result produced this cycle, if any.
	logic       emit;
	logic [7:0] emit_char;
	logic       emit_last;
	logic       emit_done;

	stk_cmd_t stk_cmd;
	op_code_t op_arr [STACK_DEPTH];

	logic out_free;
	logic in_xfer;
	logic pop_ok;
	logic next_pops;

	assign out_free = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_xfer = s_axis_tvalid && s_axis_tready;

	// The top of the stack always sits in the first cell; the second cell tells whether
	// the pop after this one would also happen.
	assign pop_ok    = (count_q != '0) && (op_arr[0][1] >= tok_q.code[1]);
	assign next_pops = (count_q > CntOne) && (op_arr[1][1] >= tok_q.code[1]);

	// Stack chain: a push moves every entry one cell away from the top, a pop one cell
	// toward it.
	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		op_code_t upper;
		op_code_t lower;
		if (i == 0) begin : g_top
			assign upper = tok_q.code;
		end else begin : g_mid
			assign upper = op_arr[i-1];
		end
		if (i == STACK_DEPTH - 1) begin : g_bottom
			assign lower = op_arr[i];
		end else begin : g_inner
			assign lower = op_arr[i+1];
		end
		itp_cell u_cell (
			.clk      (clk),
			.cmd      (stk_cmd),
			.upper_op (upper),
			.lower_op (lower),
			.op_q     (op_arr[i])
		);
	end

	// Sequencer decisions for the current cycle.
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		flag_d    = flag_q;
		stk_cmd   = STK_HOLD;
		emit      = 1'b0;
		emit_char = ch_q;
		emit_last = 1'b0;
		emit_done = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					state_d = ST_WORK;
				end
			end
			ST_WORK: begin
				if (!tok_q.is_op) begin
					// Operand: pass it straight through.
					if (out_free) begin
						emit      = 1'b1;
						emit_last = !eoe_q || (count_q == '0);
						emit_done = eoe_q && (count_q == '0);
						if (eoe_q && (count_q != '0)) begin
							state_d = ST_FLUSH;
						end else begin
							state_d = ST_IDLE;
							if (eoe_q) begin
								flag_d = 1'b0;
							end
						end
					end
				end else if (pop_ok) begin
					// Pop an operator of equal or higher precedence.
					if (out_free) begin
						emit      = 1'b1;
						emit_char = op_char(op_arr[0]);
						emit_last = !eoe_q && !next_pops;
						stk_cmd   = STK_POP;
						count_d   = count_q - CntOne;
					end
				end else begin
					// Push the operator, or drop it when the stack is full. A drop can only
					// follow an item that popped nothing, so earlier results are unaffected.
					if (count_q == CntFull) begin
						flag_d = 1'b1;
					end else begin
						stk_cmd = STK_PUSH;
						count_d = count_q + CntOne;
					end
					state_d = eoe_q ? ST_FLUSH : ST_IDLE;
				end
			end
			ST_FLUSH: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_char = op_char(op_arr[0]);
					emit_last = (count_q == CntOne);
					emit_done = (count_q == CntOne);
					stk_cmd   = STK_POP;
					count_d   = count_q - CntOne;
					if (count_q == CntOne) begin
						state_d = ST_IDLE;
						flag_d  = 1'b0;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			flag_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			flag_q  <= flag_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			ch_q  <= s_axis_tdata;
			eoe_q <= s_axis_tlast;
			tok_q <= classify(s_axis_tdata);
		end
		if (emit) begin
			out_char_q <= emit_char;
			out_last_q <= emit_last;
			out_done_q <= emit_done;
			out_ovf_q  <= flag_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_char_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = {out_ovf_q, out_done_q};

	// The stack count never passes the depth.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntFull)
		else $error("stack count above depth");

	// A flush only runs while operators remain on the stack.
	a_flush_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH) |-> (count_q != '0))
		else $error("flush with empty stack");

	// The end of an expression always closes the run of its item.
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && emit_done) |-> emit_last)
		else $error("expression end not marked as last of run");

	// After the final result of an expression the overflow flag is clear and the
	// stack is empty.
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && emit_done) |=> (!flag_q && (count_q == '0)))
		else $error("state not cleared at expression end");

endmodule

`default_nettype wire

### test/infix_to_postfix_converter_test.sv
// Self-checking testbench for infix_to_postfix_converter: drives expression characters on the
// input stream and checks the postfix characters against a behavioral operator stack.
// Depends on itp_pkg (operator characters and codes) and on the converter RTL.
`default_nettype none

module infix_to_postfix_converter_test;
	import itp_pkg::*;

	localparam int STACK_DEPTH = 32;
	localparam int CYCLE_LIMIT = 400000;

	// One postfix character as it should appear on the output stream.
	typedef struct packed {
		logic [7:0] out_char;
		logic       last_of_run;
		logic       expression_done;
		logic       overflow_seen;
	} postfix_char_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;   // [7:0] token_char
	logic       s_axis_tlast = 1'b0;    // end_of_expression
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;           // [7:0] out_char
	logic       m_axis_tlast;           // last_of_run
	logic [1:0] m_axis_tuser;           // [0] expression_done, [1] overflow_seen

	// Behavioral operator stack and the characters still owed by the block.
	op_code_t      op_stack [STACK_DEPTH];
	int            op_depth = 0;
	logic          overflow_flag = 1'b0;
	postfix_char_t pending_chars [$];
	logic [7:0]    glyph_of [4] = '{CHAR_ADD, CHAR_SUB, CHAR_MUL, CHAR_DIV};

	int send_idle_pct = 0;
	int ready_stall_pct = 0;
	int error_count = 0;
	int tokens_sent = 0;
	int expressions_sent = 0;
	int chars_checked = 0;
	int cycle_count = 0;

	infix_to_postfix_converter #(.STACK_DEPTH(STACK_DEPTH)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tuser (m_axis_tuser)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("infix_to_postfix_converter: mismatch");
			$finish;
		end
	end

	// Random back-pressure on the output stream.
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= ready_stall_pct);
	end

	// Shunting-yard step for one accepted character: operands pass straight through, an
	// operator pops everything of equal or higher precedence and is then pushed (or, with
	// the stack full, dropped and flagged), and the end of an expression flushes the stack.
	task automatic convert_token(input logic [7:0] ch, input logic at_end);
		postfix_char_t emitted [$];
		postfix_char_t entry;
		op_code_t      code;
		logic          is_op;
		is_op = 1'b1;
		code  = OP_ADD;
		entry = '0;
		case (ch)
			CHAR_ADD: code = OP_ADD;
			CHAR_SUB: code = OP_SUB;
			CHAR_MUL: code = OP_MUL;
			CHAR_DIV: code = OP_DIV;
			default:  is_op = 1'b0;
		endcase
		if (!is_op) begin
			entry.out_char = ch;
			emitted.push_back(entry);
		end else begin
			// Bit 1 of the code is the precedence level.
			while (op_depth > 0 && op_stack[op_depth - 1][1] >= code[1]) begin
				op_depth--;
				entry.out_char = glyph_of[op_stack[op_depth]];
				emitted.push_back(entry);
			end
			if (op_depth < STACK_DEPTH) begin
				op_stack[op_depth] = code;
				op_depth++;
			end else begin
				overflow_flag = 1'b1;
			end
		end
		if (at_end) begin
			while (op_depth > 0) begin
				op_depth--;
				entry.out_char = glyph_of[op_stack[op_depth]];
				emitted.push_back(entry);
			end
		end
		foreach (emitted[i]) begin
			emitted[i].overflow_seen   = overflow_flag;
			emitted[i].last_of_run     = (i == emitted.size() - 1);
			emitted[i].expression_done = at_end && (i == emitted.size() - 1);
			pending_chars.push_back(emitted[i]);
		end
		if (at_end)
			overflow_flag = 1'b0;
	endtask

	// Sends one character, with random idle cycles in front, and predicts its output once
	// the transfer has happened.
	task automatic send_token(input logic [7:0] ch, input logic at_end);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= ch;
		s_axis_tlast  <= at_end;
		do @(posedge clk); while (!s_axis_tready);
		convert_token(ch, at_end);
		tokens_sent++;
		if (at_end)
			expressions_sent++;
	endtask

	function automatic logic [7:0] random_operand();
		logic [7:0] ch;
		do ch = 8'($urandom_range(255));
		while (ch == CHAR_ADD || ch == CHAR_SUB || ch == CHAR_MUL || ch == CHAR_DIV);
		return ch;
	endfunction

	function automatic logic [7:0] random_operator();
		return glyph_of[$urandom_range(3)];
	endfunction

	// Output checker: every output transfer is compared with the oldest prediction.
	always @(posedge clk) begin
		postfix_char_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_chars.size() == 0) begin
				$error("unexpected output: out_char %h", m_axis_tdata);
				error_count++;
			end else begin
				want = pending_chars.pop_front();
				chars_checked++;
				if (m_axis_tdata !== want.out_char) begin
					$error("out_char: expected %h, got %h", want.out_char, m_axis_tdata);
					error_count++;
				end
				if (m_axis_tlast !== want.last_of_run) begin
					$error("last_of_run: expected %b, got %b", want.last_of_run, m_axis_tlast);
					error_count++;
				end
				if (m_axis_tuser[0] !== want.expression_done) begin
					$error("expression_done: expected %b, got %b", want.expression_done,
						m_axis_tuser[0]);
					error_count++;
				end
				if (m_axis_tuser[1] !== want.overflow_seen) begin
					$error("overflow_seen: expected %b, got %b", want.overflow_seen,
						m_axis_tuser[1]);
					error_count++;
				end
			end
		end
	end

	// Operands at both ends of the character range, a lone operand as a whole expression.
	task automatic test_operand_extremes();
		send_token(8'h00, 1'b1);
		send_token(8'hFF, 1'b0);
		send_token(CHAR_ADD, 1'b0);
		send_token(8'h80, 1'b0);
		send_token(CHAR_SUB, 1'b0);
		send_token(8'h7F, 1'b1);
	endtask

	// Every operator, pushes that emit nothing, and pops of equal and higher precedence.
	task automatic test_precedence();
		send_token("a", 1'b0);
		send_token(CHAR_ADD, 1'b0);
		send_token("b", 1'b0);
		send_token(CHAR_MUL, 1'b0);   // pushed above '+', nothing comes out
		send_token("c", 1'b0);
		send_token(CHAR_SUB, 1'b0);   // pops '*' and '+'
		send_token("d", 1'b0);
		send_token(CHAR_DIV, 1'b0);
		send_token("e", 1'b0);
		send_token(CHAR_DIV, 1'b0);   // equal precedence pops the earlier '/'
		send_token("f", 1'b1);
	endtask

	// Operators on an empty stack, and operators as the item that ends the expression.
	task automatic test_operator_end_items();
		send_token(CHAR_MUL, 1'b1);
		send_token(CHAR_SUB, 1'b0);
		send_token(CHAR_ADD, 1'b0);
		send_token(CHAR_MUL, 1'b0);
		send_token(CHAR_DIV, 1'b0);
		send_token("x", 1'b1);
		send_token(CHAR_DIV, 1'b0);
		send_token(CHAR_SUB, 1'b1);
	endtask

	// Mostly well-formed expressions of random length and content, with some raw noise:
	// any character and an end marker at arbitrary places.
	task automatic test_random_expressions(input int idle_pct, input int stall_pct,
		input int item_budget);
		int start_count;
		int operands;
		send_idle_pct   = idle_pct;
		ready_stall_pct = stall_pct;
		start_count     = tokens_sent;
		while (tokens_sent - start_count < item_budget) begin
			if ($urandom_range(99) < 80) begin
				operands = $urandom_range(1, 6);
				for (int i = 0; i < operands; i++) begin
					send_token(random_operand(), i == operands - 1);
					if (i != operands - 1)
						send_token(random_operator(), 1'b0);
				end
			end else begin
				repeat ($urandom_range(1, 4))
					send_token(8'($urandom_range(255)), $urandom_range(3) == 0);
			end
		end
		// Noise may leave an expression open; close it so each phase starts clean.
		send_token(random_operand(), 1'b1);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_operand_extremes();
		test_precedence();
		test_operator_end_items();
		test_random_expressions(0, 0, 67);
		test_random_expressions(77, 0, 67);
		test_random_expressions(0, 77, 67);
		test_random_expressions(29, 29, 67);
		s_axis_tvalid <= 1'b0;

		while (pending_chars.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Sent %0d characters in %0d expressions; checked %0d postfix characters",
			tokens_sent, expressions_sent, chars_checked);
		$display("under free flow, input gaps, output stalls and both combined.");
		if (error_count == 0)
			$display("infix_to_postfix_converter: match");
		else
			$display("infix_to_postfix_converter: mismatch");
		$finish;
	end

endmodule

`default_nettype wire
